// ===== design/jpc_pkg.sv =====
// Shared widths, operation codes and constants of the jackknife correlation block.
`timescale 1ns / 1ps
package jpc_pkg;
  localparam int SAMPLE_W = 16;
  localparam int CORR_W   = 16;
  localparam int PCOUNT_W = 7;
  localparam int K_W      = 17;
  localparam int STEP_W   = 5;
  localparam int OP_W     = 4;

  localparam logic [OP_W-1:0] OP_AA   = 4'd0;
  localparam logic [OP_W-1:0] OP_BB   = 4'd1;
  localparam logic [OP_W-1:0] OP_AB   = 4'd2;
  localparam logic [OP_W-1:0] OP_MAA  = 4'd3;
  localparam logic [OP_W-1:0] OP_SASA = 4'd4;
  localparam logic [OP_W-1:0] OP_MBB  = 4'd5;
  localparam logic [OP_W-1:0] OP_SBSB = 4'd6;
  localparam logic [OP_W-1:0] OP_MAB  = 4'd7;
  localparam logic [OP_W-1:0] OP_SASB = 4'd8;
  localparam logic [OP_W-1:0] OP_VAVB = 4'd9;
  localparam logic [OP_W-1:0] OP_CC   = 4'd10;
  localparam logic [OP_W-1:0] OP_END  = 4'd11;

  localparam logic [STEP_W-1:0] ROOT_FIRST = 5'd16;
  localparam int C2_SHIFT = 30;
  localparam int P_SHIFT  = 32;
  localparam logic signed [K_W:0] CORR_ONE = 18'sd32768;
  localparam logic signed [K_W:0] CORR_MAX = 18'sd32767;
endpackage

// ===== design/jpc_if.sv =====
// Request channel interfaces for sample pairs and correlation results.
`timescale 1ns / 1ps
interface jpc_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample_a;
  logic signed [15:0] sample_b;
  logic last_sample;
  modport source (output valid, sample_a, sample_b, last_sample, input ready);
  modport sink (input valid, sample_a, sample_b, last_sample, output ready);
endinterface

interface jpc_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] min_correlation;
  logic [6:0] pair_count;
  modport source (output valid, min_correlation, pair_count, input ready);
  modport sink (input valid, min_correlation, pair_count, output ready);
endinterface

// ===== design/jpc_mul.sv =====
// Shared shift-add multiplier that retires one multiplier bit per cycle.
`timescale 1ns / 1ps
module jpc_mul #(
  parameter int VW = 45
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [VW-1:0]   x,
  input  logic signed [VW-1:0]   y,
  output logic                   done,
  output logic signed [2*VW-1:0] p
);
  localparam int PW = 2 * VW;

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] xs;
  logic [VW-1:0] ys;
  logic neg;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && ys == '0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && ys == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xs  <= PW'(x);
      ys  <= y[VW-1] ? VW'(-y) : VW'(y);
      neg <= y[VW-1];
    end else if (busy) begin
      if (ys == '0) begin
        p <= neg ? -acc : acc;
      end else begin
        if (ys[0]) begin
          acc <= acc + xs;
        end
        xs <= xs <<< 1;
        ys <= ys >> 1;
      end
    end
  end
endmodule

// ===== design/jackknife_pearson_correlation.sv =====
// Top level of the leave-one-out Pearson correlation block.
//
// Usage: pairs of signed Q8.8 samples arrive on the samples channel, one
// request per cycle while the block is loading. Up to MAX_SAMPLES pairs are
// kept; further pairs of the same set are dropped. The pair with last_sample
// set closes the set and starts the search, and the block drops ready until
// the search is done. For each left-out pair one shared shift-add multiplier
// forms up to eleven products in turn (one multiplier bit per cycle, stopping
// early on short operands), and a bit-serial root search then follows. If a
// left-out variance is not positive, the last two products and the search
// are skipped and that pair counts as correlation zero.
// The result (smallest correlation in Q1.15 and the pair count) sits in an
// output register; if the receiver stalls, the block holds it there and
// waits with a finished search only when a second result is ready.
// Reset clears the running sums, the count and the output valid; the stored
// pairs are not cleared, since only pairs written in the current set are read.
`timescale 1ns / 1ps
module jackknife_pearson_correlation #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic clk,
  input  logic rst,
  jpc_in_if.sink    samples,
  jpc_out_if.source result
);
  localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNW = $clog2(MAX_SAMPLES + 1);
  localparam int SAW = 17 + AW;
  localparam int SQW = 32 + AW;
  localparam int VW  = 33 + 2 * AW;
  localparam int PW  = 2 * VW;
  localparam int W   = PW + 36;
  localparam int SW  = jpc_pkg::SAMPLE_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_ROOT = 3'd5;
  localparam logic [2:0] ST_NEXT = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state;
  logic [SW-1:0] store_a [MAX_SAMPLES];
  logic [SW-1:0] store_b [MAX_SAMPLES];
  logic signed [SW-1:0] rd_a, rd_b;

  logic [CNW-1:0] loaded_count, n, idx;
  logic signed [SAW-1:0] sum_a, sum_b, sa, sb;
  logic signed [SQW-1:0] sum_aa, sum_bb, sum_ab, saa, sbb, sab;
  logic signed [VW-1:0] va, vb, cv;
  logic signed [PW-1:0] t, pp;
  logic [jpc_pkg::OP_W-1:0] op;
  logic [W-1:0] d, u, v;
  logic [jpc_pkg::K_W-1:0] k;
  logic [jpc_pkg::STEP_W-1:0] step;
  logic signed [jpc_pkg::K_W:0] best, corr;
  logic ov;
  logic signed [jpc_pkg::CORR_W-1:0] res_corr;
  logic [jpc_pkg::PCOUNT_W-1:0] res_count;

  logic mul_start, mul_done;
  logic signed [VW-1:0] mx, my;
  logic signed [PW-1:0] mp;
  logic signed [PW-1:0] pdiff;
  logic [CNW-1:0] m;
  logic [W-1:0] s, p_ext;
  logic fit;
  logic accept, keep;
  logic signed [2*SW-1:0] pa, pb, pab;
  logic [CNW+jpc_pkg::PCOUNT_W-1:0] n_ext;

  assign samples.ready = (state == ST_IDLE);
  assign accept = samples.valid && samples.ready;
  assign keep = loaded_count < CNW'(MAX_SAMPLES);
  assign pa  = samples.sample_a * samples.sample_a;
  assign pb  = samples.sample_b * samples.sample_b;
  assign pab = samples.sample_a * samples.sample_b;
  assign m = n - 1'b1;
  assign pdiff = t - mp;
  assign s = u + v;
  assign fit = (s <= d);
  assign p_ext = {{(W-PW){1'b0}}, mp};
  assign n_ext = {{jpc_pkg::PCOUNT_W{1'b0}}, n};
  assign corr = cv[VW-1] ? -$signed({1'b0, k}) : $signed({1'b0, k});
  assign mul_start = (state == ST_MUL);

  always_comb begin
    case (op)
      jpc_pkg::OP_AA:   begin mx = VW'(rd_a); my = VW'(rd_a); end
      jpc_pkg::OP_BB:   begin mx = VW'(rd_b); my = VW'(rd_b); end
      jpc_pkg::OP_AB:   begin mx = VW'(rd_a); my = VW'(rd_b); end
      jpc_pkg::OP_MAA:  begin mx = VW'(saa); my = VW'($signed({1'b0, m})); end
      jpc_pkg::OP_SASA: begin mx = VW'(sa); my = VW'(sa); end
      jpc_pkg::OP_MBB:  begin mx = VW'(sbb); my = VW'($signed({1'b0, m})); end
      jpc_pkg::OP_SBSB: begin mx = VW'(sb); my = VW'(sb); end
      jpc_pkg::OP_MAB:  begin mx = VW'(sab); my = VW'($signed({1'b0, m})); end
      jpc_pkg::OP_SASB: begin mx = VW'(sa); my = VW'(sb); end
      jpc_pkg::OP_VAVB: begin mx = va; my = vb; end
      jpc_pkg::OP_CC:   begin mx = cv; my = cv; end
      default:          begin mx = '0; my = '0; end
    endcase
  end

  jpc_mul #(.VW(VW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mx),
    .y     (my),
    .done  (mul_done),
    .p     (mp)
  );

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      store_a[loaded_count[AW-1:0]] <= samples.sample_a;
      store_b[loaded_count[AW-1:0]] <= samples.sample_b;
    end
    rd_a <= store_a[idx[AW-1:0]];
    rd_b <= store_b[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      loaded_count <= '0;
      sum_a <= '0;
      sum_b <= '0;
      sum_aa <= '0;
      sum_bb <= '0;
      sum_ab <= '0;
      ov <= 1'b0;
      idx <= '0;
      op <= '0;
    end else begin
      if (state == ST_FIN && (!ov || result.ready)) begin
        ov <= 1'b1;
      end else if (result.valid && result.ready) begin
        ov <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (keep) begin
              loaded_count <= loaded_count + 1'b1;
              sum_a  <= sum_a + SAW'(samples.sample_a);
              sum_b  <= sum_b + SAW'(samples.sample_b);
              sum_aa <= sum_aa + SQW'(pa);
              sum_bb <= sum_bb + SQW'(pb);
              sum_ab <= sum_ab + SQW'(pab);
            end
            if (samples.last_sample) begin
              n <= keep ? loaded_count + 1'b1 : loaded_count;
              idx <= '0;
              best <= jpc_pkg::CORR_ONE;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          sa <= sum_a - SAW'(rd_a);
          sb <= sum_b - SAW'(rd_b);
          op <= jpc_pkg::OP_AA;
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            op <= op + 1'b1;
            case (op)
              jpc_pkg::OP_AA: begin
                saa <= sum_aa - mp[SQW-1:0];
                state <= ST_MUL;
              end
              jpc_pkg::OP_BB: begin
                sbb <= sum_bb - mp[SQW-1:0];
                state <= ST_MUL;
              end
              jpc_pkg::OP_AB: begin
                sab <= sum_ab - mp[SQW-1:0];
                state <= ST_MUL;
              end
              jpc_pkg::OP_MAA,
              jpc_pkg::OP_MBB,
              jpc_pkg::OP_MAB: begin
                t <= mp;
                state <= ST_MUL;
              end
              jpc_pkg::OP_SASA: begin
                va <= pdiff[VW-1:0];
                state <= ST_MUL;
              end
              jpc_pkg::OP_SBSB: begin
                vb <= pdiff[VW-1:0];
                state <= ST_MUL;
              end
              jpc_pkg::OP_SASB: begin
                cv <= pdiff[VW-1:0];
                if (va <= 0 || vb <= 0) begin
                  if (best > 0) begin
                    best <= '0;
                  end
                  state <= ST_NEXT;
                end else begin
                  state <= ST_MUL;
                end
              end
              jpc_pkg::OP_VAVB: begin
                pp <= mp;
                state <= ST_MUL;
              end
              jpc_pkg::OP_CC: begin
                d <= p_ext << jpc_pkg::C2_SHIFT;
                v <= {{(W-PW){1'b0}}, pp} << jpc_pkg::P_SHIFT;
                u <= '0;
                k <= '0;
                step <= jpc_pkg::ROOT_FIRST;
                state <= ST_ROOT;
              end
              default: state <= ST_NEXT;
            endcase
          end
        end
        ST_ROOT: begin
          if (fit) begin
            d <= d - s;
            u <= (u + (v << 1)) >> 1;
          end else begin
            u <= u >> 1;
          end
          v <= v >> 2;
          k <= {k[jpc_pkg::K_W-2:0], fit};
          if (step == '0) begin
            state <= ST_NEXT;
          end else begin
            step <= step - 1'b1;
          end
        end
        ST_NEXT: begin
          if (op == jpc_pkg::OP_END && corr < best) begin
            best <= corr;
          end
          if (idx == n - 1'b1) begin
            loaded_count <= '0;
            sum_a <= '0;
            sum_b <= '0;
            sum_aa <= '0;
            sum_bb <= '0;
            sum_ab <= '0;
            state <= ST_FIN;
          end else begin
            idx <= idx + 1'b1;
            state <= ST_READ;
          end
        end
        ST_FIN: begin
          if (!ov || result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!ov || result.ready)) begin
      res_corr  <= (best > jpc_pkg::CORR_MAX) ? jpc_pkg::CORR_MAX[jpc_pkg::CORR_W-1:0]
                                              : best[jpc_pkg::CORR_W-1:0];
      res_count <= n_ext[jpc_pkg::PCOUNT_W-1:0];
    end
  end

  assign result.valid = ov;
  assign result.min_correlation = res_corr;
  assign result.pair_count = res_count;
endmodule

// ===== design/jpc_checker.sv =====
// Port-level checks of the jackknife correlation block and their binding.
`timescale 1ns / 1ps
module jpc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_corr,
  input logic [6:0] out_count
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_corr) && $stable(out_count))
    else $error("Result payload changed while stalled.");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready && !out_valid || !in_ready)
    else $error("Block still ready after the last pair of a set.");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Reset did not clear the result and idle the block.");
endmodule

bind jackknife_pearson_correlation jpc_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_last   (samples.last_sample),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_corr  (result.min_correlation),
  .out_count (result.pair_count)
);

// ===== tb/sv/tb_jackknife_pearson_correlation.sv =====
// Testbench for the leave-one-out Pearson correlation block with an exact integer predictor.
`timescale 1ns / 1ps
module tb_jackknife_pearson_correlation;
  localparam int MAX_PAIRS = 64;
  localparam longint CYCLE_LIMIT = 64'd20000000;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic last;
  } pair_t;

  typedef struct packed {
    logic signed [15:0] corr;
    logic [6:0] count;
  } corr_t;

  logic clk;
  logic rst;
  jpc_in_if samples();
  jpc_out_if result();

  jackknife_pearson_correlation #(.MAX_SAMPLES(MAX_PAIRS)) dut (
    .clk(clk),
    .rst(rst),
    .samples(samples.sink),
    .result(result.source)
  );

  pair_t pending_pairs[$];
  corr_t expected_corr[$];
  bit failed;
  bit stim_done;
  bit in_fire;
  longint cycles;

  longint held_a[MAX_PAIRS];
  longint held_b[MAX_PAIRS];
  longint tot_a, tot_b, tot_aa, tot_bb, tot_ab;
  int held_n;

  int burst_left;
  int gap_left;
  int stall_phase;
  int stall_len;

  task automatic queue_pair(pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  function automatic int left_out_corr(int n, int skip);
    longint m, sa, sb, saa, sbb, sab, va, vb, cv;
    logic [191:0] prod, rhs, lhs, cmag;
    int lo, hi, mid;
    m = n - 1;
    sa = tot_a - held_a[skip];
    sb = tot_b - held_b[skip];
    saa = tot_aa - held_a[skip] * held_a[skip];
    sbb = tot_bb - held_b[skip] * held_b[skip];
    sab = tot_ab - held_a[skip] * held_b[skip];
    va = m * saa - sa * sa;
    vb = m * sbb - sb * sb;
    cv = m * sab - sa * sb;
    if (va <= 0 || vb <= 0) return 0;
    prod = 192'(va) * 192'(vb);
    cmag = (cv < 0) ? 192'(-cv) : 192'(cv);
    rhs = (cmag * cmag) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 192'(longint'(mid) * longint'(mid)) * prod;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (cv < 0) ? -lo : lo;
  endfunction

  task automatic predict_pair(pair_t p);
    int best, c;
    corr_t r;
    best = 32768;
    if (held_n < MAX_PAIRS) begin
      held_a[held_n] = p.a;
      held_b[held_n] = p.b;
      tot_a += p.a;
      tot_b += p.b;
      tot_aa += longint'(p.a) * p.a;
      tot_bb += longint'(p.b) * p.b;
      tot_ab += longint'(p.a) * p.b;
      held_n++;
    end
    if (p.last) begin
      for (int i = 0; i < held_n; i++) begin
        c = left_out_corr(held_n, i);
        if (c < best) best = c;
      end
      if (best > 32767) best = 32767;
      r.corr = 16'(best);
      r.count = 7'(held_n);
      expected_corr.insert(expected_corr.size(), r);
      tot_a = 0; tot_b = 0; tot_aa = 0; tot_bb = 0; tot_ab = 0;
      held_n = 0;
    end
  endtask

  task automatic add_set(int n, int kind);
    pair_t p;
    int base, scale;
    base = $urandom_range(0, 2000) - 1000;
    scale = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: begin
          p.a = 16'($urandom);
          p.b = 16'($urandom);
        end
        1: begin
          p.a = 16'(base + i * scale + $urandom_range(0, 30));
          p.b = 16'(2 * base + i * scale + $urandom_range(0, 30));
        end
        2: begin
          p.a = 16'(base + i * scale + $urandom_range(0, 30));
          p.b = 16'(-base - i * scale + $urandom_range(0, 30));
        end
        default: begin
          p.a = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          p.b = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end
      endcase
      p.last = (i == n - 1);
      queue_pair(p);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int n;
    rst = 1'b1;
    queue_pair('{16'sh7fff, 16'sh8000, 1'b1});
    queue_pair('{16'sh0100, 16'sh0100, 1'b0});
    queue_pair('{16'sh0100, 16'sh0100, 1'b1});
    queue_pair('{16'sh7fff, 16'sh7fff, 1'b0});
    queue_pair('{16'sh8000, 16'sh8000, 1'b0});
    queue_pair('{16'sh0000, 16'sh0000, 1'b1});
    queue_pair('{16'sh7fff, 16'sh8000, 1'b0});
    queue_pair('{16'sh8000, 16'sh7fff, 1'b0});
    queue_pair('{16'sh0001, 16'shffff, 1'b1});
    add_set(4, 1);
    add_set(4, 2);
    // The store fills up here, and the pairs past it are dropped.
    add_set(MAX_PAIRS + 3, 0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    n = 0;
    while (n < 1500) begin
      case ($urandom_range(0, 9))
        0: add_set($urandom_range(MAX_PAIRS - 2, MAX_PAIRS + 4), $urandom_range(0, 3));
        1: add_set(1, 0);
        default: add_set($urandom_range(2, 12), $urandom_range(0, 3));
      endcase
      n = pending_pairs.size();
    end
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (rst) in_fire <= 1'b0;
    else in_fire <= samples.valid && samples.ready;
  end

  always @(negedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
      samples.sample_a <= '0;
      samples.sample_b <= '0;
      samples.last_sample <= 1'b0;
      burst_left <= $urandom_range(1, 20);
      gap_left <= 0;
    end else if (!samples.valid || in_fire) begin
      if (gap_left > 0 || pending_pairs.size() == 0) begin
        samples.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        samples.valid <= 1'b1;
        samples.sample_a <= pending_pairs[0].a;
        samples.sample_b <= pending_pairs[0].b;
        samples.last_sample <= pending_pairs[0].last;
        void'(pending_pairs.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_phase <= 0;
      stall_len <= 40;
    end else begin
      stall_phase <= (stall_phase + 1) % stall_len;
      if (stall_phase == 0) stall_len <= $urandom_range(10, 400);
      result.ready <= (stall_len < 100) || (stall_phase % 7 != 3 && stall_phase % 11 != 5);
    end
  end

  always @(posedge clk) begin
    corr_t want;
    if (!rst) begin
      if (samples.valid && samples.ready)
        predict_pair('{samples.sample_a, samples.sample_b, samples.last_sample});
      if (result.valid && result.ready) begin
        if (expected_corr.size() == 0) begin
          $error("unexpected result: min_correlation %0d pair_count %0d",
                 result.min_correlation, result.pair_count);
          failed = 1'b1;
        end else begin
          want = expected_corr.pop_front();
          if (result.min_correlation !== want.corr) begin
            $error("min_correlation expected %0d actual %0d", want.corr,
                   result.min_correlation);
            failed = 1'b1;
          end
          if (result.pair_count !== want.count) begin
            $error("pair_count expected %0d actual %0d", want.count, result.pair_count);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    failed = 1'b0;
    stim_done = 1'b0;
    wait (stim_done);
    wait (pending_pairs.size() == 0);
    @(posedge clk);
    while (samples.valid || expected_corr.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/jpc_pkg.sv
design/jpc_if.sv
design/jpc_mul.sv
design/jackknife_pearson_correlation.sv
design/jpc_checker.sv
tb/sv/tb_jackknife_pearson_correlation.sv
